[design/assert_macros.svh]
// assertion macros shared by the checker files
// needs clk, and arst_n for CCIRC_ASSERT, in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is applied
`define CCIRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds while reset is applied
`define CCIRC_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/ccirc_pkg.sv]
// ccirc_pkg: item and result types, fixed widths and helpers of the circumcircle unit
// no dependencies
package ccirc_pkg;

	localparam int IN_W = 16;
	localparam int OUT_W = 48;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH = 4;

	// offset magnitude up to the clamp value 2^49
	localparam int OFS_W = 50;
	localparam int UMAG_W = 49;
	localparam int UHI_W = 24;
	localparam int ULO_W = 25;
	localparam int SQ_W = 98;
	localparam int V_W = 100;
	localparam int ROOT_W = 50;
	localparam int CSUM_W = 52;

	localparam logic [OFS_W-1:0] OFS_LIM = OFS_W'(1) << (OFS_W - 1);
	localparam logic [OUT_W-1:0] SMAX48 = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic [OUT_W-1:0] SMIN48 = {1'b1, {(OUT_W - 1){1'b0}}};

	typedef enum logic [1:0] {
		ST_VALID = 2'd0,
		ST_COLLINEAR = 2'd1,
		ST_SATURATED = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [IN_W-1:0] ax;
		logic signed [IN_W-1:0] ay;
		logic signed [IN_W-1:0] bx;
		logic signed [IN_W-1:0] by_coord;
		logic signed [IN_W-1:0] cx_in;
		logic signed [IN_W-1:0] cy_in;
	} item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] centre_x;
		logic signed [OUT_W-1:0] centre_y;
		logic [OUT_W-1:0] circle_radius;
		status_t status;
	} result_t;

	// width of the classified record handed from front to back
	function automatic int rec_width(input int w);
		return 1 + 2 * w + 4 * (w + 1) + (2 * w + 4) + 2 * (2 * w + 2);
	endfunction

endpackage

[design/ccirc_front.sv]
// ccirc_front: accepts point triples, forms edge vectors, determinant and squared lengths
// depends on ccirc_pkg
module ccirc_front #(
	parameter int COORD_WIDTH = ccirc_pkg::COORD_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input ccirc_pkg::item_t item,
	output logic rec_push,
	input logic rec_full,
	output logic [ccirc_pkg::rec_width(COORD_WIDTH)-1:0] rec
);
	import ccirc_pkg::*;

	localparam int W = COORD_WIDTH;
	localparam int DW = W + 1;
	localparam int PW = 2 * DW;
	localparam int SQW = 2 * W + 2;
	localparam int DNW = 2 * W + 4;

	typedef struct packed {
		logic coll;
		logic signed [W-1:0] ax;
		logic signed [W-1:0] ay;
		logic signed [DW-1:0] bxd;
		logic signed [DW-1:0] byd;
		logic signed [DW-1:0] cxd;
		logic signed [DW-1:0] cyd;
		logic signed [DNW-1:0] den;
		logic [SQW-1:0] sb;
		logic [SQW-1:0] sc;
	} rec_t;

	// only the low coordinate bits count, taken as two's complement
	function automatic logic signed [W-1:0] crd(input logic [IN_W-1:0] f);
		crd = $signed(W'(f));
	endfunction

	logic fe;
	logic v_s1, v_s2, v_s3;
	logic signed [W-1:0] ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3;
	logic signed [DW-1:0] bxd_s1, byd_s1, cxd_s1, cyd_s1;
	logic signed [DW-1:0] bxd_s2, byd_s2, cxd_s2, cyd_s2;
	logic signed [DW-1:0] bxd_s3, byd_s3, cxd_s3, cyd_s3;
	logic signed [PW-1:0] pbc_s2, pcb_s2, sqbx_s2, sqby_s2, sqcx_s2, sqcy_s2;
	logic signed [DNW-1:0] den_s3;
	logic [SQW-1:0] sb_s3, sc_s3;
	logic coll_s3;
	rec_t rec_c;

	assign fe = !v_s3 || !rec_full;
	assign full = !fe;
	assign rec_push = v_s3 && !rec_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (fe) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			ax_s1 <= crd(item.ax);
			ay_s1 <= crd(item.ay);
			bxd_s1 <= DW'(crd(item.bx)) - DW'(crd(item.ax));
			byd_s1 <= DW'(crd(item.by_coord)) - DW'(crd(item.ay));
			cxd_s1 <= DW'(crd(item.cx_in)) - DW'(crd(item.ax));
			cyd_s1 <= DW'(crd(item.cy_in)) - DW'(crd(item.ay));

			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			bxd_s2 <= bxd_s1;
			byd_s2 <= byd_s1;
			cxd_s2 <= cxd_s1;
			cyd_s2 <= cyd_s1;
			pbc_s2 <= bxd_s1 * cyd_s1;
			pcb_s2 <= byd_s1 * cxd_s1;
			sqbx_s2 <= bxd_s1 * bxd_s1;
			sqby_s2 <= byd_s1 * byd_s1;
			sqcx_s2 <= cxd_s1 * cxd_s1;
			sqcy_s2 <= cyd_s1 * cyd_s1;

			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			bxd_s3 <= bxd_s2;
			byd_s3 <= byd_s2;
			cxd_s3 <= cxd_s2;
			cyd_s3 <= cyd_s2;
			den_s3 <= (DNW'(pbc_s2) - DNW'(pcb_s2)) <<< 1;
			coll_s3 <= (pbc_s2 == pcb_s2);
			sb_s3 <= SQW'(sqbx_s2) + SQW'(sqby_s2);
			sc_s3 <= SQW'(sqcx_s2) + SQW'(sqcy_s2);
		end
	end

	always_comb begin
		rec_c.coll = coll_s3;
		rec_c.ax = ax_s3;
		rec_c.ay = ay_s3;
		rec_c.bxd = bxd_s3;
		rec_c.byd = byd_s3;
		rec_c.cxd = cxd_s3;
		rec_c.cyd = cyd_s3;
		rec_c.den = den_s3;
		rec_c.sb = sb_s3;
		rec_c.sc = sc_s3;
	end

	assign rec = rec_c;

endmodule

[design/ccirc_queue.sv]
// ccirc_queue: short register queue between the front and back parts
// depends on nothing but its parameters
module ccirc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [WIDTH-1:0] din,
	input logic pop,
	output logic empty,
	output logic [WIDTH-1:0] dout
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

[design/ccirc_back.sv]
// ccirc_back: numerators, pipelined dividers, centre saturation and pipelined square root
// depends on ccirc_pkg
module ccirc_back #(
	parameter int COORD_WIDTH = ccirc_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS = ccirc_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic rec_empty,
	output logic rec_pop,
	input logic [ccirc_pkg::rec_width(COORD_WIDTH)-1:0] rec,
	output logic empty,
	input logic pop,
	output ccirc_pkg::result_t result
);
	import ccirc_pkg::*;

	localparam int W = COORD_WIDTH;
	localparam int F = FRAC_BITS;
	localparam int DW = W + 1;
	localparam int SQW = 2 * W + 2;
	localparam int DNW = 2 * W + 4;
	localparam int HW = W + 1;
	localparam int PW = DW + HW + 1;
	localparam int NXW = 3 * W + 5;
	localparam int NMW = 3 * W + 4;
	localparam int NB = NMW + F;
	localparam int RR_W = ROOT_W + 2;
	localparam int SQ_N = ROOT_W;

	typedef struct packed {
		logic coll;
		logic signed [W-1:0] ax;
		logic signed [W-1:0] ay;
		logic signed [DW-1:0] bxd;
		logic signed [DW-1:0] byd;
		logic signed [DW-1:0] cxd;
		logic signed [DW-1:0] cyd;
		logic signed [DNW-1:0] den;
		logic [SQW-1:0] sb;
		logic [SQW-1:0] sc;
	} rec_t;

	// signed edge component times one half of a squared length
	function automatic logic signed [PW-1:0] pmul(input logic signed [DW-1:0] a,
			input logic [HW-1:0] b);
		pmul = a * $signed({1'b0, b});
	endfunction

	rec_t r_in;
	logic adv;
	logic out_v_q;
	result_t res_q;

	assign r_in = rec;
	assign adv = !out_v_q || pop;
	assign rec_pop = adv && !rec_empty;
	assign empty = !out_v_q;
	assign result = res_q;

	// s1: partial products of the numerators
	logic v_s1, coll_s1;
	logic signed [W-1:0] ax_s1, ay_s1;
	logic signed [DNW-1:0] den_s1;
	logic signed [PW-1:0] pcl_s1, pch_s1, pbl_s1, pbh_s1, pxl_s1, pxh_s1, pdl_s1, pdh_s1;
	// s2: numerators
	logic v_s2, coll_s2;
	logic signed [W-1:0] ax_s2, ay_s2;
	logic signed [DNW-1:0] den_s2;
	logic signed [NXW-1:0] nx_s2, ny_s2;

	// divider pipeline, entry 0 is loaded from s2
	logic v_sdiv [NB+1];
	logic coll_sdiv [NB+1];
	logic negx_sdiv [NB+1];
	logic negy_sdiv [NB+1];
	logic signed [W-1:0] ax_sdiv [NB+1];
	logic signed [W-1:0] ay_sdiv [NB+1];
	logic [DNW-1:0] dm_sdiv [NB+1];
	logic [NB-1:0] numx_sdiv [NB+1];
	logic [NB-1:0] numy_sdiv [NB+1];
	logic [DNW-1:0] remx_sdiv [NB+1];
	logic [DNW-1:0] remy_sdiv [NB+1];
	logic [OFS_W-1:0] qx_sdiv [NB+1];
	logic [OFS_W-1:0] qy_sdiv [NB+1];
	logic bigx_sdiv [NB+1];
	logic bigy_sdiv [NB+1];

	// s4: rounded and clamped offset magnitudes
	logic v_s4, coll_s4, clamp_s4, negx_s4, negy_s4;
	logic signed [W-1:0] ax_s4, ay_s4;
	logic [OFS_W-1:0] qmx_s4, qmy_s4;
	logic [OFS_W:0] qrx_c, qry_c;
	logic rndx_c, rndy_c, clx_c, cly_c;
	// s5: signed offsets and partial squares
	logic v_s5, coll_s5, clamp_s5;
	logic signed [W-1:0] ax_s5, ay_s5;
	logic signed [OFS_W:0] qsx_s5, qsy_s5;
	logic [2*UHI_W-1:0] hhx_s5, hhy_s5;
	logic [UHI_W+ULO_W-1:0] hlx_s5, hly_s5;
	logic [2*ULO_W-1:0] llx_s5, lly_s5;
	// s6: centre with saturation, squared offsets
	logic v_s6, coll_s6, clamp_s6, sat_s6;
	logic [OUT_W-1:0] cx_s6, cy_s6;
	logic [SQ_W-1:0] sqx_s6, sqy_s6;
	logic signed [CSUM_W-1:0] csx_c, csy_c;
	logic satx_c, saty_c;
	// s7 is entry 0 of the root pipeline

	logic v_ssqr [SQ_N+1];
	logic coll_ssqr [SQ_N+1];
	logic clamp_ssqr [SQ_N+1];
	logic sat_ssqr [SQ_N+1];
	logic [OUT_W-1:0] cx_ssqr [SQ_N+1];
	logic [OUT_W-1:0] cy_ssqr [SQ_N+1];
	logic [V_W-1:0] vv_ssqr [SQ_N+1];
	logic [RR_W-1:0] rem_ssqr [SQ_N+1];
	logic [ROOT_W-1:0] root_ssqr [SQ_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_sdiv[0] <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_ssqr[0] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= !rec_empty;
			v_s2 <= v_s1;
			v_sdiv[0] <= v_s2;
			v_s4 <= v_sdiv[NB];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_ssqr[0] <= v_s6;
			out_v_q <= v_ssqr[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coll_s1 <= r_in.coll;
			ax_s1 <= r_in.ax;
			ay_s1 <= r_in.ay;
			den_s1 <= r_in.den;
			pcl_s1 <= pmul(r_in.cyd, r_in.sb[HW-1:0]);
			pch_s1 <= pmul(r_in.cyd, r_in.sb[SQW-1:HW]);
			pbl_s1 <= pmul(r_in.byd, r_in.sc[HW-1:0]);
			pbh_s1 <= pmul(r_in.byd, r_in.sc[SQW-1:HW]);
			pxl_s1 <= pmul(r_in.bxd, r_in.sc[HW-1:0]);
			pxh_s1 <= pmul(r_in.bxd, r_in.sc[SQW-1:HW]);
			pdl_s1 <= pmul(r_in.cxd, r_in.sb[HW-1:0]);
			pdh_s1 <= pmul(r_in.cxd, r_in.sb[SQW-1:HW]);

			coll_s2 <= coll_s1;
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			den_s2 <= den_s1;
			nx_s2 <= (NXW'(pch_s1) <<< HW) + NXW'(pcl_s1)
				- (NXW'(pbh_s1) <<< HW) - NXW'(pbl_s1);
			ny_s2 <= (NXW'(pxh_s1) <<< HW) + NXW'(pxl_s1)
				- (NXW'(pdh_s1) <<< HW) - NXW'(pdl_s1);

			// magnitudes and quotient signs enter the dividers
			coll_sdiv[0] <= coll_s2;
			ax_sdiv[0] <= ax_s2;
			ay_sdiv[0] <= ay_s2;
			negx_sdiv[0] <= nx_s2[NXW-1] ^ den_s2[DNW-1];
			negy_sdiv[0] <= ny_s2[NXW-1] ^ den_s2[DNW-1];
			dm_sdiv[0] <= den_s2[DNW-1] ? DNW'(-den_s2) : DNW'(den_s2);
			numx_sdiv[0] <= NB'(nx_s2[NXW-1] ? NMW'(-nx_s2) : NMW'(nx_s2)) << F;
			numy_sdiv[0] <= NB'(ny_s2[NXW-1] ? NMW'(-ny_s2) : NMW'(ny_s2)) << F;
			remx_sdiv[0] <= '0;
			remy_sdiv[0] <= '0;
			qx_sdiv[0] <= '0;
			qy_sdiv[0] <= '0;
			bigx_sdiv[0] <= 1'b0;
			bigy_sdiv[0] <= 1'b0;
		end
	end

	// one quotient bit per stage, restoring division
	for (genvar k = 0; k < NB; k++) begin : g_div
		logic [DNW:0] tx, ty;
		logic gex, gey;

		assign tx = {remx_sdiv[k], numx_sdiv[k][NB-1]};
		assign ty = {remy_sdiv[k], numy_sdiv[k][NB-1]};
		assign gex = (tx >= {1'b0, dm_sdiv[k]});
		assign gey = (ty >= {1'b0, dm_sdiv[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sdiv[k+1] <= 1'b0;
			end else if (adv) begin
				v_sdiv[k+1] <= v_sdiv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				coll_sdiv[k+1] <= coll_sdiv[k];
				ax_sdiv[k+1] <= ax_sdiv[k];
				ay_sdiv[k+1] <= ay_sdiv[k];
				negx_sdiv[k+1] <= negx_sdiv[k];
				negy_sdiv[k+1] <= negy_sdiv[k];
				dm_sdiv[k+1] <= dm_sdiv[k];
				numx_sdiv[k+1] <= numx_sdiv[k] << 1;
				numy_sdiv[k+1] <= numy_sdiv[k] << 1;
				remx_sdiv[k+1] <= gex ? DNW'(tx - {1'b0, dm_sdiv[k]}) : DNW'(tx);
				remy_sdiv[k+1] <= gey ? DNW'(ty - {1'b0, dm_sdiv[k]}) : DNW'(ty);
				qx_sdiv[k+1] <= {qx_sdiv[k][OFS_W-2:0], gex};
				qy_sdiv[k+1] <= {qy_sdiv[k][OFS_W-2:0], gey};
				// quotient bits above the kept window only mean overflow
				bigx_sdiv[k+1] <= bigx_sdiv[k] | qx_sdiv[k][OFS_W-1];
				bigy_sdiv[k+1] <= bigy_sdiv[k] | qy_sdiv[k][OFS_W-1];
			end
		end
	end

	// round half away from zero, then clamp to 2^49
	always_comb begin
		rndx_c = ({remx_sdiv[NB], 1'b0} >= {1'b0, dm_sdiv[NB]});
		rndy_c = ({remy_sdiv[NB], 1'b0} >= {1'b0, dm_sdiv[NB]});
		qrx_c = {1'b0, qx_sdiv[NB]} + (OFS_W + 1)'(rndx_c);
		qry_c = {1'b0, qy_sdiv[NB]} + (OFS_W + 1)'(rndy_c);
		clx_c = bigx_sdiv[NB] || (qrx_c[OFS_W:OFS_W-1] != 2'b00);
		cly_c = bigy_sdiv[NB] || (qry_c[OFS_W:OFS_W-1] != 2'b00);
	end

	// centre saturation: fits when the bits above the 48-bit sign all agree
	always_comb begin
		csx_c = (CSUM_W'(ax_s5) <<< F) + CSUM_W'(qsx_s5);
		csy_c = (CSUM_W'(ay_s5) <<< F) + CSUM_W'(qsy_s5);
		satx_c = (csx_c[CSUM_W-1:OUT_W-1] != '0) && (csx_c[CSUM_W-1:OUT_W-1] != '1);
		saty_c = (csy_c[CSUM_W-1:OUT_W-1] != '0) && (csy_c[CSUM_W-1:OUT_W-1] != '1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coll_s4 <= coll_sdiv[NB];
			ax_s4 <= ax_sdiv[NB];
			ay_s4 <= ay_sdiv[NB];
			negx_s4 <= negx_sdiv[NB];
			negy_s4 <= negy_sdiv[NB];
			clamp_s4 <= clx_c || cly_c;
			qmx_s4 <= clx_c ? OFS_LIM : qrx_c[OFS_W-1:0];
			qmy_s4 <= cly_c ? OFS_LIM : qry_c[OFS_W-1:0];

			coll_s5 <= coll_s4;
			clamp_s5 <= clamp_s4;
			ax_s5 <= ax_s4;
			ay_s5 <= ay_s4;
			qsx_s5 <= negx_s4 ? -$signed({1'b0, qmx_s4}) : $signed({1'b0, qmx_s4});
			qsy_s5 <= negy_s4 ? -$signed({1'b0, qmy_s4}) : $signed({1'b0, qmy_s4});
			hhx_s5 <= qmx_s4[UMAG_W-1:ULO_W] * qmx_s4[UMAG_W-1:ULO_W];
			hlx_s5 <= qmx_s4[UMAG_W-1:ULO_W] * qmx_s4[ULO_W-1:0];
			llx_s5 <= qmx_s4[ULO_W-1:0] * qmx_s4[ULO_W-1:0];
			hhy_s5 <= qmy_s4[UMAG_W-1:ULO_W] * qmy_s4[UMAG_W-1:ULO_W];
			hly_s5 <= qmy_s4[UMAG_W-1:ULO_W] * qmy_s4[ULO_W-1:0];
			lly_s5 <= qmy_s4[ULO_W-1:0] * qmy_s4[ULO_W-1:0];

			coll_s6 <= coll_s5;
			clamp_s6 <= clamp_s5;
			sat_s6 <= satx_c || saty_c;
			cx_s6 <= satx_c ? (csx_c[CSUM_W-1] ? SMIN48 : SMAX48) : csx_c[OUT_W-1:0];
			cy_s6 <= saty_c ? (csy_c[CSUM_W-1] ? SMIN48 : SMAX48) : csy_c[OUT_W-1:0];
			sqx_s6 <= (SQ_W'(hhx_s5) << (2 * ULO_W)) + (SQ_W'(hlx_s5) << (ULO_W + 1))
				+ SQ_W'(llx_s5);
			sqy_s6 <= (SQ_W'(hhy_s5) << (2 * ULO_W)) + (SQ_W'(hly_s5) << (ULO_W + 1))
				+ SQ_W'(lly_s5);

			coll_ssqr[0] <= coll_s6;
			clamp_ssqr[0] <= clamp_s6;
			sat_ssqr[0] <= sat_s6;
			cx_ssqr[0] <= cx_s6;
			cy_ssqr[0] <= cy_s6;
			vv_ssqr[0] <= V_W'(sqx_s6) + V_W'(sqy_s6);
			rem_ssqr[0] <= '0;
			root_ssqr[0] <= '0;
		end
	end

	// one root bit per stage, two radicand bits consumed each time
	for (genvar k = 0; k < SQ_N; k++) begin : g_sqr
		logic [RR_W+1:0] cur, trial;
		logic ge;

		assign cur = {rem_ssqr[k], vv_ssqr[k][V_W-1:V_W-2]};
		assign trial = (RR_W + 2)'({root_ssqr[k], 2'b01});
		assign ge = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_ssqr[k+1] <= 1'b0;
			end else if (adv) begin
				v_ssqr[k+1] <= v_ssqr[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				coll_ssqr[k+1] <= coll_ssqr[k];
				clamp_ssqr[k+1] <= clamp_ssqr[k];
				sat_ssqr[k+1] <= sat_ssqr[k];
				cx_ssqr[k+1] <= cx_ssqr[k];
				cy_ssqr[k+1] <= cy_ssqr[k];
				vv_ssqr[k+1] <= vv_ssqr[k] << 2;
				rem_ssqr[k+1] <= ge ? RR_W'(cur - trial) : RR_W'(cur);
				root_ssqr[k+1] <= {root_ssqr[k][ROOT_W-2:0], ge};
			end
		end
	end

	// output register, holds while the receiver stalls
	logic rsat_c, big_c;
	result_t res_c;

	always_comb begin
		rsat_c = (root_ssqr[SQ_N][ROOT_W-1:OUT_W] != '0);
		big_c = clamp_ssqr[SQ_N] || rsat_c;
		res_c.centre_x = cx_ssqr[SQ_N];
		res_c.centre_y = cy_ssqr[SQ_N];
		res_c.circle_radius = big_c ? '1 : root_ssqr[SQ_N][OUT_W-1:0];
		res_c.status = (big_c || sat_ssqr[SQ_N]) ? ST_SATURATED : ST_VALID;
		if (coll_ssqr[SQ_N]) begin
			res_c.centre_x = '0;
			res_c.centre_y = '0;
			res_c.circle_radius = '0;
			res_c.status = ST_COLLINEAR;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_c;
		end
	end

endmodule

[design/circumcircle_of_three_points_unit.sv]
// circumcircle_of_three_points_unit: top level of the circumcircle unit
// depends on ccirc_pkg, ccirc_front, ccirc_queue, ccirc_back
//
// usage
//   input side is a queue: drive item and raise push; the item is taken at a
//   rising edge where push is high and full is low
//   result side is a queue: while empty is low the oldest result sits on
//   result; it is taken at a rising edge where pop is high
//   each item gives exactly one result, in order
// timing
//   the pipeline length comes from the restoring divider (one quotient bit per
//   stage) and the 50-stage root
//   throughput is one item per cycle while pop keeps up
// stall behavior
//   a waiting result freezes the back pipeline; the front keeps taking items
//   into its registers and the four-entry queue until those fill, then full
//   rises
// reset
//   arst_n low empties every stage: empty high, full low; no clearing pass
module circumcircle_of_three_points_unit #(
	parameter int COORD_WIDTH = ccirc_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS = ccirc_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input ccirc_pkg::item_t item,
	output logic empty,
	input logic pop,
	output ccirc_pkg::result_t result
);
	import ccirc_pkg::*;

	localparam int REC_W = rec_width(COORD_WIDTH);

	// classified record from front into queue
	logic rec_push, rec_full;
	logic [REC_W-1:0] rec_in;
	// queue head into back
	logic rec_pop, rec_empty;
	logic [REC_W-1:0] rec_out;

	// front: coordinate extraction, edge vectors, determinant, squared lengths, collinear flag
	ccirc_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.rec_push(rec_push),
		.rec_full(rec_full),
		.rec(rec_in)
	);

	// decouples front and back stalls
	ccirc_queue #(
		.WIDTH(REC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(rec_push),
		.full(rec_full),
		.din(rec_in),
		.pop(rec_pop),
		.empty(rec_empty),
		.dout(rec_out)
	);

	// back: numerators, dividers, saturation, square root, output register
	ccirc_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.rec_empty(rec_empty),
		.rec_pop(rec_pop),
		.rec(rec_out),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule

[design/ccirc_checker.sv]
// ccirc_checker: port-level checks of the circumcircle unit, bound to the top level
// depends on ccirc_pkg and assert_macros.svh
`include "assert_macros.svh"

module ccirc_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic empty,
	input logic pop,
	input ccirc_pkg::result_t result
);
	import ccirc_pkg::*;

	// items accepted but not yet delivered
	logic [9:0] outst_q;
	logic in_acc, out_acc;
	logic coll_shown, fields_zero;

	assign in_acc = push && !full;
	assign out_acc = pop && !empty;
	assign coll_shown = !empty && (result.status == ST_COLLINEAR);
	assign fields_zero = (result.centre_x == '0) && (result.centre_y == '0)
		&& (result.circle_radius == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else if (in_acc && !out_acc) begin
			outst_q <= outst_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			outst_q <= outst_q - 1'b1;
		end
	end

	`CCIRC_ASSERT_NR(a_reset_empty, !arst_n |-> empty, "result shown during reset")
	`CCIRC_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(result), "stalled result changed")
	`CCIRC_ASSERT(a_coll_zero, coll_shown |-> fields_zero, "collinear result not zero")
	`CCIRC_ASSERT(a_no_extra, out_acc |-> outst_q != '0, "result without an accepted item")

endmodule

bind circumcircle_of_three_points_unit ccirc_checker u_chk (.*);
